// ===== design/wsd_pkg.sv =====
// Shared types, fixed-point constants and helpers for the Wigner small-d evaluator.
// Used by every module of the block; depends on nothing.
package wsd_pkg;

  localparam int unsigned ANGLE_W  = 16;  // input angle width
  localparam int unsigned QF       = 30;  // internal fraction bits
  localparam int unsigned QW       = 33;  // internal Q30 datapath width
  localparam int unsigned TW       = 34;  // CORDIC residual angle width
  localparam int unsigned PW       = 2 * QW;
  localparam int unsigned POLY_LAT = 4;   // register stages after the CORDIC chain
  localparam logic [1:0]  MAX_RANK = 2'd2;

  localparam int unsigned DEF_FRAC_BITS    = 14;
  localparam int unsigned DEF_CORDIC_STEPS = 16;

  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

  localparam logic signed [QW-1:0] Q_ONE  = 33'sd1073741824;
  localparam logic signed [QW-1:0] Q_GAIN = 33'sd652032874;
  localparam logic signed [QW-1:0] Q_RTH  = 33'sd759250125;
  localparam logic signed [QW-1:0] Q_RT32 = 33'sd1315059792;
  localparam logic signed [QW-1:0] Q_RT38 = 33'sd657529896;
  localparam logic signed [PW-1:0] Q_RND  = PW'(1) << (QF - 1);

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  // closed form selected for the canonical (j, m1, m2) pair
  typedef enum logic [3:0] {
    FORM_ONE,
    FORM_COS,
    FORM_HP,
    FORM_HM,
    FORM_SIN_RH,
    FORM_LEG2,
    FORM_HP_2CM1,
    FORM_HM_2CP1,
    FORM_RT32_SC,
    FORM_HPHP,
    FORM_HPS,
    FORM_RT38_SS,
    FORM_HMS,
    FORM_HMHM
  } form_t;

  typedef struct packed {
    logic  valid;
    logic  bad;
    logic  neg;
    form_t form;
  } tag_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [TW-1:0] t;
    logic                 neg_cos;
  } rot_t;

  // Q30 product, rounded half up
  function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    p = p + Q_RND;
    return QW'(p >>> QF);
  endfunction

endpackage

// ===== design/wsd_reduce_cell.sv =====
// One step of the angle reduction chain: conditional subtract of 2*pi scaled by 2^SHIFT.
// Depends on wsd_pkg.
module wsd_reduce_cell
  import wsd_pkg::*;
#(
  parameter int unsigned RW    = 32,
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [RW-1:0] t_i,
  input  tag_t          tag_i,
  output logic [RW-1:0] t_o,
  output tag_t          tag_o
);

  localparam logic [63:0] SUB = Q30_TWO_PI << SHIFT;

  logic [RW-1:0] t_r, t_nxt;
  tag_t          tag_r;

  always_comb begin
    if (64'(t_i) >= SUB) begin
      t_nxt = RW'(64'(t_i) - SUB);
    end else begin
      t_nxt = t_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
  end

  assign t_o   = t_r;
  assign tag_o = tag_r;

endmodule

// ===== design/wsd_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation with a fixed shift of STEP.
// Depends on wsd_pkg.
module wsd_cordic_cell
  import wsd_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  rot_t rot_i,
  input  tag_t tag_i,
  output rot_t rot_o,
  output tag_t tag_o
);

  localparam logic signed [TW-1:0] ATAN = TW'(ATAN_Q30[STEP]);

  rot_t rot_r, rot_nxt;
  tag_t tag_r;

  always_comb begin
    rot_nxt         = rot_i;
    if (!rot_i.t[TW-1]) begin
      rot_nxt.x = rot_i.x - (rot_i.y >>> STEP);
      rot_nxt.y = rot_i.y + (rot_i.x >>> STEP);
      rot_nxt.t = rot_i.t - ATAN;
    end else begin
      rot_nxt.x = rot_i.x + (rot_i.y >>> STEP);
      rot_nxt.y = rot_i.y - (rot_i.x >>> STEP);
      rot_nxt.t = rot_i.t + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  assign rot_o = rot_r;
  assign tag_o = tag_r;

endmodule

// ===== design/wsd_poly.sv =====
// Closed-form evaluation from cos/sin: half terms, up to two Q30 products,
// sign, rounding to FRAC_BITS and saturation. Depends on wsd_pkg.
module wsd_poly
  import wsd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rot_t                        rot_i,
  input  tag_t                        tag_i,
  output logic                        valid_o,
  output logic signed [FRAC_BITS+1:0] d_o,
  output logic                        bad_o
);

  localparam int unsigned SH = QF - FRAC_BITS;
  localparam logic signed [QW:0] ONE_F = (QW+1)'(1) << FRAC_BITS;

  // stage A: cos, sin, (1 +- cos)/2
  logic signed [QW-1:0] c_a_nxt, c_a_r, s_a_r, hp_a_nxt, hp_a_r, hm_a_nxt, hm_a_r;
  tag_t                 tag_a_r;

  always_comb begin
    c_a_nxt  = rot_i.neg_cos ? -rot_i.x : rot_i.x;
    hp_a_nxt = (Q_ONE + c_a_nxt) >>> 1;
    hm_a_nxt = (Q_ONE - c_a_nxt) >>> 1;
  end

  // stage B: first product
  logic signed [QW-1:0] op_a, op_b, p1_b_nxt, p1_b_r, c_b_r, hp_b_r, hm_b_r;
  tag_t                 tag_b_r;

  always_comb begin
    case (tag_a_r.form)
      FORM_SIN_RH: begin
        op_a = s_a_r;
        op_b = Q_RTH;
      end
      FORM_HP_2CM1: begin
        op_a = hp_a_r;
        op_b = (c_a_r <<< 1) - Q_ONE;
      end
      FORM_HM_2CP1: begin
        op_a = hm_a_r;
        op_b = (c_a_r <<< 1) + Q_ONE;
      end
      FORM_RT32_SC: begin
        op_a = Q_RT32;
        op_b = s_a_r;
      end
      FORM_HPHP: begin
        op_a = hp_a_r;
        op_b = hp_a_r;
      end
      FORM_HPS: begin
        op_a = hp_a_r;
        op_b = s_a_r;
      end
      FORM_RT38_SS: begin
        op_a = s_a_r;
        op_b = s_a_r;
      end
      FORM_HMS: begin
        op_a = hm_a_r;
        op_b = s_a_r;
      end
      FORM_HMHM: begin
        op_a = hm_a_r;
        op_b = hm_a_r;
      end
      default: begin
        op_a = c_a_r;
        op_b = c_a_r;
      end
    endcase
    p1_b_nxt = qmul(op_a, op_b);
  end

  // stage C: second product or final selection
  logic signed [QW-1:0] op_c, d_c_nxt, d_c_r;
  logic signed [QW+1:0] leg_ext, leg3;
  tag_t                 tag_c_r;

  always_comb begin
    op_c    = (tag_b_r.form == FORM_RT38_SS) ? Q_RT38 : c_b_r;
    leg_ext = (QW+2)'(p1_b_r);
    leg3    = leg_ext + (leg_ext <<< 1) - (QW+2)'(Q_ONE);
    case (tag_b_r.form)
      FORM_ONE:     d_c_nxt = Q_ONE;
      FORM_COS:     d_c_nxt = c_b_r;
      FORM_HP:      d_c_nxt = hp_b_r;
      FORM_HM:      d_c_nxt = hm_b_r;
      FORM_LEG2:    d_c_nxt = QW'(leg3 >>> 1);
      FORM_RT32_SC: d_c_nxt = qmul(p1_b_r, op_c);
      FORM_RT38_SS: d_c_nxt = qmul(p1_b_r, op_c);
      default:      d_c_nxt = p1_b_r;
    endcase
  end

  // stage D: sign, round, saturate
  logic signed [QW:0]          d_n, d_rnd;
  logic signed [QW:0]          d_sat;
  logic signed [FRAC_BITS+1:0] d_d_r;
  logic                        bad_d_r, valid_d_r;

  assign d_n = tag_c_r.neg ? -((QW+1)'(d_c_r)) : (QW+1)'(d_c_r);

  generate
    if (SH > 0) begin : g_round
      localparam logic signed [QW:0] RND = (QW+1)'(1) << (SH - 1);
      assign d_rnd = (d_n + RND) >>> SH;
    end else begin : g_exact
      assign d_rnd = d_n;
    end
  endgenerate

  always_comb begin
    if (d_rnd > ONE_F) begin
      d_sat = ONE_F;
    end else if (d_rnd < -ONE_F) begin
      d_sat = -ONE_F;
    end else begin
      d_sat = d_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r   <= '0;
      tag_b_r   <= '0;
      tag_c_r   <= '0;
      valid_d_r <= 1'b0;
      bad_d_r   <= 1'b0;
    end else begin
      tag_a_r   <= tag_i;
      tag_b_r   <= tag_a_r;
      tag_c_r   <= tag_b_r;
      valid_d_r <= tag_c_r.valid;
      bad_d_r   <= tag_c_r.bad;
    end
  end

  always_ff @(posedge clk) begin
    c_a_r  <= c_a_nxt;
    s_a_r  <= rot_i.y;
    hp_a_r <= hp_a_nxt;
    hm_a_r <= hm_a_nxt;
    p1_b_r <= p1_b_nxt;
    c_b_r  <= c_a_r;
    hp_b_r <= hp_a_r;
    hm_b_r <= hm_a_r;
    d_c_r  <= d_c_nxt;
    // drop the value on a bad index
    d_d_r  <= tag_c_r.bad ? '0 : (FRAC_BITS+2)'(d_sat);
  end

  assign valid_o = valid_d_r;
  assign d_o     = d_d_r;
  assign bad_o   = bad_d_r;

endmodule

// ===== design/wigner_small_d_eval.sv =====
// Wigner small-d evaluator, d^j_{m1,m2}(theta) for j up to 2: top level.
// From start to out_valid an item passes the RED angle-reduction cells (RED = 1 for Q2.14
// angles at the defaults), the fold register, the CORDIC chain and the wsd_poly stages.
// Throughput: one item per cycle; every stage advances each cycle; busy drops after reset.
// Results appear once on out_valid and are never held. Synchronous active-low reset
// clears all valid flags and holds busy high. Depends on wsd_pkg, the cell modules and wsd_poly.
module wigner_small_d_eval
  import wsd_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = DEF_FRAC_BITS,
  parameter int unsigned CORDIC_STEPS = DEF_CORDIC_STEPS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_rank,
  input  logic signed [2:0]           in_m_first,
  input  logic signed [2:0]           in_m_second,
  input  logic [ANGLE_W-1:0]          in_angle,
  output logic                        out_valid,
  output logic signed [FRAC_BITS+1:0] out_d_value,
  output logic                        out_bad_index
);

  localparam int unsigned RW       = ANGLE_W + QF - FRAC_BITS;
  localparam logic [63:0] QMAX     = (((64'd1 << ANGLE_W) - 64'd1) << (QF - FRAC_BITS))
                                     / Q30_TWO_PI;
  localparam int unsigned RED_BITS = $clog2(QMAX + 64'd1);
  localparam int unsigned RED      = (RED_BITS > 0) ? RED_BITS : 1;
  localparam int unsigned LAT      = RED + CORDIC_STEPS + 1 + POLY_LAT;
  localparam int unsigned FW       = QW + 2;

  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // index checks and symmetry folding onto a canonical pair
  logic              accept;
  logic signed [3:0] m1e, m2e, a1, a2, s1, s2, c1, c2, rk;
  logic              in_bad, swap, negm, neg_flip, form_neg;
  form_t             form;
  tag_t              tag_in;

  always_comb begin
    accept   = start && !busy_r;
    m1e      = 4'(in_m_first);
    m2e      = 4'(in_m_second);
    rk       = $signed({2'b00, in_rank});
    a1       = (m1e < 0) ? -m1e : m1e;
    a2       = (m2e < 0) ? -m2e : m2e;
    in_bad   = (in_rank > MAX_RANK) || (a1 > rk) || (a2 > rk);
    swap     = a2 > a1;
    s1       = swap ? m2e : m1e;
    s2       = swap ? m1e : m2e;
    negm     = s1 < 0;
    c1       = negm ? -s1 : s1;
    c2       = negm ? -s2 : s2;
    neg_flip = (swap ^ negm) && (c1[0] ^ c2[0]);
    form_neg = 1'b0;
    form     = FORM_ONE;
    if (in_rank == 2'd1) begin
      if (c1 == 4'sd0) begin
        form = FORM_COS;
      end else if (c2 == 4'sd1) begin
        form = FORM_HP;
      end else if (c2 == 4'sd0) begin
        form     = FORM_SIN_RH;
        form_neg = 1'b1;
      end else begin
        form = FORM_HM;
      end
    end else if (in_rank == MAX_RANK) begin
      if (c1 == 4'sd0) begin
        form = FORM_LEG2;
      end else if (c1 == 4'sd1) begin
        if (c2 == 4'sd1) begin
          form = FORM_HP_2CM1;
        end else if (c2 == 4'sd0) begin
          form     = FORM_RT32_SC;
          form_neg = 1'b1;
        end else begin
          form = FORM_HM_2CP1;
        end
      end else begin
        if (c2 == 4'sd2) begin
          form = FORM_HPHP;
        end else if (c2 == 4'sd1) begin
          form     = FORM_HPS;
          form_neg = 1'b1;
        end else if (c2 == 4'sd0) begin
          form = FORM_RT38_SS;
        end else if (c2 == -4'sd1) begin
          form     = FORM_HMS;
          form_neg = 1'b1;
        end else begin
          form = FORM_HMHM;
        end
      end
    end
    tag_in.valid = accept;
    tag_in.bad   = in_bad;
    tag_in.neg   = form_neg ^ neg_flip;
    tag_in.form  = form;
  end

  // angle reduction modulo 2*pi, one quotient bit per cell
  logic [RW-1:0] red_t   [RED+1];
  tag_t          red_tag [RED+1];

  assign red_t[0]   = RW'(in_angle) << (QF - FRAC_BITS);
  assign red_tag[0] = tag_in;

  genvar g;
  generate
    for (g = 0; g < RED; g++) begin : g_red
      wsd_reduce_cell #(
        .RW    (RW),
        .SHIFT (RED - 1 - g)
      ) u_red (
        .clk   (clk),
        .rst_n (rst_n),
        .t_i   (red_t[g]),
        .tag_i (red_tag[g]),
        .t_o   (red_t[g+1]),
        .tag_o (red_tag[g+1])
      );
    end
  endgenerate

  // fold into [-pi/2, pi/2], noting a cosine sign flip
  logic [FW-1:0] tz;
  rot_t          fold_nxt, fold_r;
  tag_t          fold_tag_r;

  always_comb begin
    tz               = FW'(red_t[RED]);
    fold_nxt.x       = Q_GAIN;
    fold_nxt.y       = '0;
    fold_nxt.neg_cos = 1'b0;
    if (tz <= FW'(Q30_HALF_PI)) begin
      fold_nxt.t = TW'(tz);
    end else if (tz < FW'(Q30_TWO_PI - Q30_HALF_PI)) begin
      fold_nxt.t       = TW'(FW'(Q30_PI) - tz);
      fold_nxt.neg_cos = 1'b1;
    end else begin
      fold_nxt.t = TW'(tz - FW'(Q30_TWO_PI));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_tag_r <= '0;
    end else begin
      fold_tag_r <= red_tag[RED];
    end
  end

  always_ff @(posedge clk) begin
    fold_r <= fold_nxt;
  end

  // CORDIC chain
  rot_t cr_rot [CORDIC_STEPS+1];
  tag_t cr_tag [CORDIC_STEPS+1];

  assign cr_rot[0] = fold_r;
  assign cr_tag[0] = fold_tag_r;

  generate
    for (g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      wsd_cordic_cell #(
        .STEP (g)
      ) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .rot_i (cr_rot[g]),
        .tag_i (cr_tag[g]),
        .rot_o (cr_rot[g+1]),
        .tag_o (cr_tag[g+1])
      );
    end
  endgenerate

  wsd_poly #(
    .FRAC_BITS (FRAC_BITS)
  ) u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .rot_i   (cr_rot[CORDIC_STEPS]),
    .tag_i   (cr_tag[CORDIC_STEPS]),
    .valid_o (out_valid),
    .d_o     (out_d_value),
    .bad_o   (out_bad_index)
  );

`ifndef NO_ASSERTIONS
  a_out_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("result strobe does not match accepted item");

  a_bad_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bad_index == $past(in_bad, LAT))
    else $error("bad index flag does not match item");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> out_d_value == '0)
    else $error("nonzero value with bad index");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((FRAC_BITS+3)'(out_d_value) <= ((FRAC_BITS+3)'(1) << FRAC_BITS)) &&
                  ((FRAC_BITS+3)'(out_d_value) >= -((FRAC_BITS+3)'(1) << FRAC_BITS)))
    else $error("value outside [-1, +1]");
`endif

endmodule
